### rtl/core/closest_point_per_reference_select_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the closest point per reference selector
// Concurrent checks. Defining ASSERT_OFF compiles them out.
// ----------------------------------------------------------------------------
`ifndef CLOSEST_POINT_PER_REFERENCE_SELECT_TOP_MACROS_SVH
`define CLOSEST_POINT_PER_REFERENCE_SELECT_TOP_MACROS_SVH

`ifndef ASSERT_OFF

// property holds at every clock edge outside reset
`define CPS_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// consequent holds in the cycle after the antecedent
`define CPS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define CPS_ASSERT(lbl, clk, rst, prop)
`define CPS_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

### rtl/core/cprs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cprs_pkg
// Shared constants, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package cprs_pkg;

   localparam int MAX_REFS   = 256;
   localparam int COORD_BITS = 24;

   localparam int ADDR_BITS = (MAX_REFS > 1) ? $clog2(MAX_REFS) : 1;
   localparam int CNT_BITS  = $clog2(MAX_REFS + 1);

   // request / response field widths
   localparam int CMD_W    = 3;
   localparam int SLOT_W   = 8;
   localparam int POS_W    = 24;
   localparam int INDEX_W  = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 9;

   // csr
   localparam int SEP_W      = 24;
   localparam int TRACK_W    = 9;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 24;

   // distance arithmetic
   localparam int DIST_BITS   = 49;
   localparam int SQ_BITS     = 2 * COORD_BITS;
   localparam int SUM_BITS    = SQ_BITS + 1;
   localparam int THRESH_BITS = 2 * SEP_W;
   localparam int CMP_BITS    = (SUM_BITS > DIST_BITS) ? SUM_BITS : DIST_BITS;

   localparam logic [CMD_W-1:0] CMD_LOAD    = CMD_W'(0);
   localparam logic [CMD_W-1:0] CMD_POINT   = CMD_W'(1);
   localparam logic [CMD_W-1:0] CMD_READ    = CMD_W'(2);
   localparam logic [CMD_W-1:0] CMD_QUERY   = CMD_W'(3);
   localparam logic [CMD_W-1:0] CMD_RESTART = CMD_W'(4);

   localparam logic [CSR_IDX_W-1:0] CSR_MIN_SEP     = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_TRACK_COUNT = CSR_IDX_W'(1);

   typedef enum logic [STATUS_W-1:0] {
      STATUS_DONE,
      STATUS_SLOT_RANGE,
      STATUS_SATURATED
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_SWEEP,
      ST_QUERY,
      ST_READ,
      ST_DRAIN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic                 capture;
      logic                 issue;
      logic [ADDR_BITS-1:0] issue_addr;
      logic                 read_slot;
      logic                 finish;
   } ctrl_cmd_type;

   typedef struct packed {
      logic [CMD_W-1:0]    cmd;
      logic                slot_oor;
      logic                saturated;
      logic [CNT_BITS-1:0] used_count;
      logic                pipe_busy;
      logic                out_free;
   } dp_status_type;

endpackage

### rtl/core/cprs_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cprs_ctrl
// Request sequencer: dispatches each request and walks the slot index.
// ----------------------------------------------------------------------------
module cprs_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  cprs_pkg::dp_status_type dp_status,
   output cprs_pkg::ctrl_cmd_type  ctrl_cmd
);
   import cprs_pkg::*;

   state_type           state_ff, state_in;
   logic [CNT_BITS-1:0] idx_ff, idx_in;
   logic                last_track;
   logic                last_query;

   assign last_track = (idx_ff == (dp_status.used_count - CNT_BITS'(1)));
   assign last_query = (idx_ff == CNT_BITS'(MAX_REFS - 1));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            unique case (dp_status.cmd)
               CMD_POINT: begin
                  if (dp_status.saturated || (dp_status.used_count == '0)) begin
                     state_in = ST_DONE;
                  end else begin
                     state_in = ST_SWEEP;
                  end
               end
               CMD_QUERY: state_in = ST_QUERY;
               CMD_READ: begin
                  state_in = dp_status.slot_oor ? ST_DONE : ST_READ;
               end
               default: state_in = ST_DONE;
            endcase
         end
         ST_SWEEP: begin
            if (last_track) begin
               state_in = ST_DRAIN;
            end
         end
         ST_QUERY: begin
            if (last_query) begin
               state_in = ST_DRAIN;
            end
         end
         ST_READ:  state_in = ST_DONE;
         ST_DRAIN: begin
            if (!dp_status.pipe_busy) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (dp_status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      idx_in = idx_ff;
      unique case (state_ff)
         ST_DISPATCH:       idx_in = '0;
         ST_SWEEP, ST_QUERY: idx_in = idx_ff + CNT_BITS'(1);
         default:           idx_in = idx_ff;
      endcase
   end

   always_comb begin
      req_stall           = (state_ff != ST_IDLE);
      ctrl_cmd.capture    = (state_ff == ST_IDLE) && req_valid;
      ctrl_cmd.issue      = (state_ff == ST_SWEEP) || (state_ff == ST_QUERY);
      ctrl_cmd.issue_addr = idx_ff[ADDR_BITS-1:0];
      ctrl_cmd.read_slot  = (state_ff == ST_READ);
      ctrl_cmd.finish     = (state_ff == ST_DONE) && dp_status.out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

endmodule

### rtl/core/cprs_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cprs_datapath
// Reference and best-match stores, distance pipeline and response register.
// ----------------------------------------------------------------------------
module cprs_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [cprs_pkg::CMD_W-1:0]          req_cmd,
   input  logic [cprs_pkg::SLOT_W-1:0]         req_slot,
   input  logic signed [cprs_pkg::POS_W-1:0]   req_pos_x,
   input  logic signed [cprs_pkg::POS_W-1:0]   req_pos_y,
   input  logic [cprs_pkg::INDEX_W-1:0]        req_query_index,
   input  logic                                csr_we,
   input  logic [cprs_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [cprs_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  cprs_pkg::ctrl_cmd_type              ctrl_cmd,
   output cprs_pkg::dp_status_type             dp_status,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [cprs_pkg::STATUS_W-1:0]       rsp_status,
   output logic                                rsp_chosen_valid,
   output logic [cprs_pkg::INDEX_W-1:0]        rsp_chosen_index,
   output logic [cprs_pkg::DIST_BITS-1:0]      rsp_chosen_dist_sq,
   output logic                                rsp_point_selected,
   output logic [cprs_pkg::COUNT_W-1:0]        rsp_selected_count
);
   import cprs_pkg::*;

   // configuration
   logic [SEP_W-1:0]       min_sep_ff, min_sep_in;
   logic [TRACK_W-1:0]     track_count_ff, track_count_in;
   logic [THRESH_BITS-1:0] thresh_ff;
   logic [CNT_BITS-1:0]    used_count;

   // captured request
   logic [CMD_W-1:0]             cmd_ff;
   logic [SLOT_W-1:0]            slot_ff;
   logic signed [COORD_BITS-1:0] px_ff, py_ff;
   logic [INDEX_W-1:0]           query_ff;
   logic [ADDR_BITS-1:0]         slot_addr;
   logic                         slot_oor;
   logic                         saturated;

   // search state
   logic [INDEX_W-1:0]  point_counter_ff, point_counter_in;
   logic [CNT_BITS-1:0] total_ff, total_in;
   logic [MAX_REFS-1:0] has_choice_ff, has_choice_in;
   logic                sel_ff, sel_in;

   // stores
   logic signed [COORD_BITS-1:0] ref_x_mem [MAX_REFS];
   logic signed [COORD_BITS-1:0] ref_y_mem [MAX_REFS];
   logic [DIST_BITS-1:0]         best_dist_mem [MAX_REFS];
   logic [INDEX_W-1:0]           best_point_mem [MAX_REFS];

   logic                         rd_en;
   logic [ADDR_BITS-1:0]         rd_addr;
   logic signed [COORD_BITS-1:0] mx_ff, my_ff;
   logic [DIST_BITS-1:0]         mbd_ff;
   logic [INDEX_W-1:0]           mbp_ff;

   // distance pipeline
   logic                  v1_ff, v2_ff, v3_ff, v4_ff;
   logic                  v2_in;
   logic [ADDR_BITS-1:0]  k1_ff, k2_ff, k3_ff, k4_ff;
   logic [COORD_BITS:0]   diff_x, diff_y, mag_x, mag_y;
   logic [COORD_BITS-1:0] dx_ff, dy_ff;
   logic [SQ_BITS-1:0]    sqx_ff, sqy_ff;
   logic [SUM_BITS-1:0]   dist_ff;
   logic [DIST_BITS-1:0]  bd2_ff, bd3_ff, bd4_ff;
   logic [DIST_BITS-1:0]  best_eff;
   logic                  upd;
   logic                  query_hit;

   // response
   logic                  out_free;
   logic                  is_load, is_point, is_read, is_query, is_restart;
   logic                  rsp_valid_ff, rsp_valid_in;
   status_type            status_ff, status_in;
   logic                  cvalid_ff, cvalid_in;
   logic [INDEX_W-1:0]    cindex_ff, cindex_in;
   logic [DIST_BITS-1:0]  cdist_ff, cdist_in;
   logic                  psel_ff, psel_in;
   logic [COUNT_W-1:0]    count_ff, count_in;

   assign used_count = (int'(track_count_ff) > MAX_REFS) ? CNT_BITS'(MAX_REFS)
                                                         : CNT_BITS'(track_count_ff);
   assign slot_addr  = ADDR_BITS'(slot_ff);
   assign slot_oor   = (int'(slot_ff) >= MAX_REFS);
   assign saturated  = &point_counter_ff;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   assign is_load    = (cmd_ff == CMD_LOAD);
   assign is_point   = (cmd_ff == CMD_POINT);
   assign is_read    = (cmd_ff == CMD_READ);
   assign is_query   = (cmd_ff == CMD_QUERY);
   assign is_restart = (cmd_ff == CMD_RESTART);

   always_comb begin
      dp_status.cmd        = cmd_ff;
      dp_status.slot_oor   = slot_oor;
      dp_status.saturated  = saturated;
      dp_status.used_count = used_count;
      dp_status.pipe_busy  = v1_ff || v2_ff || v3_ff || v4_ff;
      dp_status.out_free   = out_free;
   end

   // csr writes
   always_comb begin
      min_sep_in     = min_sep_ff;
      track_count_in = track_count_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_MIN_SEP:     min_sep_in     = csr_wdata[SEP_W-1:0];
            CSR_TRACK_COUNT: track_count_in = csr_wdata[TRACK_W-1:0];
         endcase
      end
   end

   // store read port
   assign rd_en   = ctrl_cmd.issue || ctrl_cmd.read_slot;
   assign rd_addr = ctrl_cmd.read_slot ? slot_addr : ctrl_cmd.issue_addr;

   // stage 2: absolute coordinate differences
   always_comb begin
      diff_x = {px_ff[COORD_BITS-1], px_ff} - {mx_ff[COORD_BITS-1], mx_ff};
      diff_y = {py_ff[COORD_BITS-1], py_ff} - {my_ff[COORD_BITS-1], my_ff};
      mag_x  = diff_x[COORD_BITS] ? (~diff_x + 1'b1) : diff_x;
      mag_y  = diff_y[COORD_BITS] ? (~diff_y + 1'b1) : diff_y;
   end

   assign v2_in = v1_ff && is_point;

   // stage 5: compare and update
   assign best_eff = has_choice_ff[k4_ff] ? bd4_ff : '1;
   assign upd = v4_ff
             && (CMP_BITS'(dist_ff) < CMP_BITS'(best_eff))
             && (CMP_BITS'(dist_ff) <= CMP_BITS'(thresh_ff));

   assign query_hit = v1_ff && is_query && has_choice_ff[k1_ff] && (mbp_ff == query_ff);

   // search state
   always_comb begin
      has_choice_in    = has_choice_ff;
      total_in         = total_ff;
      point_counter_in = point_counter_ff;
      sel_in           = sel_ff;
      if (ctrl_cmd.capture) begin
         sel_in = 1'b0;
      end
      if (upd) begin
         has_choice_in[k4_ff] = 1'b1;
         sel_in               = 1'b1;
         if (!has_choice_ff[k4_ff]) begin
            total_in = total_ff + CNT_BITS'(1);
         end
      end
      if (query_hit) begin
         sel_in = 1'b1;
      end
      if (ctrl_cmd.finish) begin
         if (is_restart) begin
            has_choice_in    = '0;
            total_in         = '0;
            point_counter_in = '0;
         end else if (is_point && !saturated) begin
            point_counter_in = point_counter_ff + INDEX_W'(1);
         end
      end
   end

   // response build
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      status_in    = status_ff;
      cvalid_in    = cvalid_ff;
      cindex_in    = cindex_ff;
      cdist_in     = cdist_ff;
      psel_in      = psel_ff;
      count_in     = count_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (ctrl_cmd.finish) begin
         rsp_valid_in = 1'b1;
         status_in    = STATUS_DONE;
         cvalid_in    = 1'b0;
         cindex_in    = '0;
         cdist_in     = '0;
         psel_in      = (is_point || is_query) ? sel_ff : 1'b0;
         count_in     = is_restart ? '0 : COUNT_W'(total_ff);
         if ((is_load || is_read) && slot_oor) begin
            status_in = STATUS_SLOT_RANGE;
         end else if (is_point && saturated) begin
            status_in = STATUS_SATURATED;
         end else if (is_read) begin
            // an empty slot shows the cleared values
            cvalid_in = has_choice_ff[slot_addr];
            cindex_in = has_choice_ff[slot_addr] ? mbp_ff : '0;
            cdist_in  = has_choice_ff[slot_addr] ? mbd_ff : '1;
         end
      end
   end

   // stores
   always_ff @(posedge clock) begin
      if (ctrl_cmd.finish && is_load && !slot_oor) begin
         ref_x_mem[slot_addr] <= px_ff;
         ref_y_mem[slot_addr] <= py_ff;
      end
      if (upd) begin
         best_dist_mem[k4_ff]  <= DIST_BITS'(dist_ff);
         best_point_mem[k4_ff] <= point_counter_ff;
      end
      if (rd_en) begin
         mx_ff  <= ref_x_mem[rd_addr];
         my_ff  <= ref_y_mem[rd_addr];
         mbd_ff <= best_dist_mem[rd_addr];
         mbp_ff <= best_point_mem[rd_addr];
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      thresh_ff <= min_sep_ff * min_sep_ff;
      if (ctrl_cmd.capture) begin
         cmd_ff   <= req_cmd;
         slot_ff  <= req_slot;
         px_ff    <= req_pos_x[COORD_BITS-1:0];
         py_ff    <= req_pos_y[COORD_BITS-1:0];
         query_ff <= req_query_index;
      end
      k1_ff   <= ctrl_cmd.issue_addr;
      k2_ff   <= k1_ff;
      k3_ff   <= k2_ff;
      k4_ff   <= k3_ff;
      dx_ff   <= mag_x[COORD_BITS-1:0];
      dy_ff   <= mag_y[COORD_BITS-1:0];
      bd2_ff  <= mbd_ff;
      sqx_ff  <= dx_ff * dx_ff;
      sqy_ff  <= dy_ff * dy_ff;
      bd3_ff  <= bd2_ff;
      dist_ff <= SUM_BITS'(sqx_ff) + SUM_BITS'(sqy_ff);
      bd4_ff  <= bd3_ff;
      status_ff <= status_in;
      cvalid_ff <= cvalid_in;
      cindex_ff <= cindex_in;
      cdist_ff  <= cdist_in;
      psel_ff   <= psel_in;
      count_ff  <= count_in;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         min_sep_ff       <= '0;
         track_count_ff   <= '0;
         point_counter_ff <= '0;
         total_ff         <= '0;
         has_choice_ff    <= '0;
         sel_ff           <= 1'b0;
         v1_ff            <= 1'b0;
         v2_ff            <= 1'b0;
         v3_ff            <= 1'b0;
         v4_ff            <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         min_sep_ff       <= min_sep_in;
         track_count_ff   <= track_count_in;
         point_counter_ff <= point_counter_in;
         total_ff         <= total_in;
         has_choice_ff    <= has_choice_in;
         sel_ff           <= sel_in;
         v1_ff            <= ctrl_cmd.issue;
         v2_ff            <= v2_in;
         v3_ff            <= v2_ff;
         v4_ff            <= v3_ff;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = status_ff;
   assign rsp_chosen_valid   = cvalid_ff;
   assign rsp_chosen_index   = cindex_ff;
   assign rsp_chosen_dist_sq = cdist_ff;
   assign rsp_point_selected = psel_ff;
   assign rsp_selected_count = count_ff;

endmodule

### rtl/core/closest_point_per_reference_select_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// closest_point_per_reference_select_top
// Keeps the closest sample point per reference slot within a separation limit.
// ----------------------------------------------------------------------------
//
//   port group  direction  handshake         carries
//   req_*       in         req_valid/stall   cmd, slot, pos_x, pos_y, query_index
//   rsp_*       out        rsp_valid/stall   status, chosen_*, point_selected, count
//   csr_*       in         csr_we            min_sep (index 0), track_count (index 1)
//
// Flow: a process request walks the first track_count slots (clamped to the
//   slot count), the distance pipeline reading one reference slot per cycle,
//   then drains the pipeline; a query walks every best-match entry; a read
//   passes through the store read state; load, restart, unknown codes and a
//   process request with no slots in use or a saturated counter go straight
//   to the response. The next request can be taken once the response is loaded.
// Reset: clears control, choice flags and counters; no clearing pass.
//   Reference slots hold garbage until loaded.
// Stalls: one request is in work at a time. The next request is taken while a
//   response still sits in the output register; it completes once that
//   register has been emptied.
//
module closest_point_per_reference_select_top (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [cprs_pkg::CMD_W-1:0]          req_cmd,
   input  logic [cprs_pkg::SLOT_W-1:0]         req_slot,
   input  logic signed [cprs_pkg::POS_W-1:0]   req_pos_x,
   input  logic signed [cprs_pkg::POS_W-1:0]   req_pos_y,
   input  logic [cprs_pkg::INDEX_W-1:0]        req_query_index,
   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [cprs_pkg::STATUS_W-1:0]       rsp_status,
   output logic                                rsp_chosen_valid,
   output logic [cprs_pkg::INDEX_W-1:0]        rsp_chosen_index,
   output logic [cprs_pkg::DIST_BITS-1:0]      rsp_chosen_dist_sq,
   output logic                                rsp_point_selected,
   output logic [cprs_pkg::COUNT_W-1:0]        rsp_selected_count,
   // configuration
   input  logic                                csr_we,
   input  logic [cprs_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [cprs_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import cprs_pkg::*;

`include "closest_point_per_reference_select_top_macros.svh"

   ctrl_cmd_type  ctrl_cmd;
   dp_status_type dp_status;

   // Sequencer: accepts a request in idle, dispatches on the command, walks
   // the slot index for process and query, then hands the result to the
   // output register once it is free.
   cprs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .dp_status (dp_status),
      .ctrl_cmd  (ctrl_cmd)
   );

   // Datapath: reference and best-match stores, a four-stage distance
   // pipeline (abs diff, squares, sum, compare/update), counters and the
   // response register.
   cprs_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .req_cmd            (req_cmd),
      .req_slot           (req_slot),
      .req_pos_x          (req_pos_x),
      .req_pos_y          (req_pos_y),
      .req_query_index    (req_query_index),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .ctrl_cmd           (ctrl_cmd),
      .dp_status          (dp_status),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_chosen_valid   (rsp_chosen_valid),
      .rsp_chosen_index   (rsp_chosen_index),
      .rsp_chosen_dist_sq (rsp_chosen_dist_sq),
      .rsp_point_selected (rsp_point_selected),
      .rsp_selected_count (rsp_selected_count)
   );

   // an accepted request always keeps the block busy in the following cycle
   `CPS_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall)

   // a saturated counter never reports a selection or a slot result
   `CPS_ASSERT(a_saturated_quiet, clock, reset, (rsp_valid && (rsp_status == STATUS_SATURATED)) |-> (!rsp_point_selected && !rsp_chosen_valid))

   // a slot result only comes from a successful read
   `CPS_ASSERT(a_read_result_clean, clock, reset, (rsp_valid && rsp_chosen_valid) |-> ((rsp_status == STATUS_DONE) && !rsp_point_selected))

   // the request side is never released while the controller is mid-request
   `CPS_ASSERT(a_no_accept_in_work, clock, reset, (ctrl_cmd.issue || ctrl_cmd.read_slot || dp_status.pipe_busy) |-> req_stall)

endmodule

### verif/tb_closest_point_per_reference_select_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_closest_point_per_reference_select_top
// Self-checking bench for the closest point per reference selector. A queue of
// requests feeds a clocked driver. An in-bench model of the slot table, bests
// and counters predicts each response, and a clocked monitor compares every
// response field against it. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb_closest_point_per_reference_select_top;
   import cprs_pkg::*;

   // command codes the block ignores
   localparam logic [CMD_W-1:0] CMD_SPARE_5 = CMD_W'(5);
   localparam logic [CMD_W-1:0] CMD_SPARE_6 = CMD_W'(6);
   localparam logic [CMD_W-1:0] CMD_SPARE_7 = CMD_W'(7);

   localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
   localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};
   localparam logic [SEP_W-1:0]        SEP_MAX = '1;

   localparam int IDLE_PCT     = 36;    // idle / stall chance per cycle, percent
   localparam int DRAIN_CYCLES = 300;   // quiet time after the last response, longer than any request takes

   typedef struct {
      logic [CMD_W-1:0]        cmd;
      logic [SLOT_W-1:0]       slot;
      logic signed [POS_W-1:0] pos_x;
      logic signed [POS_W-1:0] pos_y;
      logic [INDEX_W-1:0]      query_index;
   } request_type;

   typedef struct {
      status_type           status;
      logic                 chosen_valid;
      logic [INDEX_W-1:0]   chosen_index;
      logic [DIST_BITS-1:0] chosen_dist;
      logic                 selected;
      logic [COUNT_W-1:0]   count;
   } answer_type;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   logic [CMD_W-1:0]          req_cmd;
   logic [SLOT_W-1:0]         req_slot;
   logic signed [POS_W-1:0]   req_pos_x;
   logic signed [POS_W-1:0]   req_pos_y;
   logic [INDEX_W-1:0]        req_query_index;
   logic                      rsp_valid;
   logic                      rsp_stall;
   logic [STATUS_W-1:0]       rsp_status;
   logic                      rsp_chosen_valid;
   logic [INDEX_W-1:0]        rsp_chosen_index;
   logic [DIST_BITS-1:0]      rsp_chosen_dist_sq;
   logic                      rsp_point_selected;
   logic [COUNT_W-1:0]        rsp_selected_count;
   logic                      csr_we;
   logic [CSR_IDX_W-1:0]      csr_index;
   logic [CSR_DATA_W-1:0]     csr_wdata;

   closest_point_per_reference_select_top u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_cmd            (req_cmd),
      .req_slot           (req_slot),
      .req_pos_x          (req_pos_x),
      .req_pos_y          (req_pos_y),
      .req_query_index    (req_query_index),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_chosen_valid   (rsp_chosen_valid),
      .rsp_chosen_index   (rsp_chosen_index),
      .rsp_chosen_dist_sq (rsp_chosen_dist_sq),
      .rsp_point_selected (rsp_point_selected),
      .rsp_selected_count (rsp_selected_count),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   // ---------------------------------------------------------------------
   // Bench state
   // ---------------------------------------------------------------------
   request_type requests_pending[$];   // filled by the stimulus, drained by the driver
   answer_type  answers_due[$];        // predicted responses, oldest first
   logic        req_taken;             // request accepted at the last rising edge
   bit          steady;                // no idling on either side while set

   // predictor copy of the block state
   logic signed [POS_W-1:0] anchor_x [MAX_REFS];
   logic signed [POS_W-1:0] anchor_y [MAX_REFS];
   logic [DIST_BITS-1:0]    closest_dist [MAX_REFS];
   logic [INDEX_W-1:0]      closest_point [MAX_REFS];
   bit                      has_pick [MAX_REFS];
   logic [INDEX_W-1:0]      point_seq;
   logic [COUNT_W-1:0]      pick_total;
   logic [SEP_W-1:0]        sep_cfg;
   logic [TRACK_W-1:0]      tracks_cfg;

   // stimulus-side shadow, only used to aim the generated requests
   logic signed [POS_W-1:0] plan_x [MAX_REFS];
   logic signed [POS_W-1:0] plan_y [MAX_REFS];
   bit                      loaded [MAX_REFS];
   int                      plan_used;
   int unsigned             plan_span;
   int                      plan_points;

   int n_queued, n_answered, n_errors;
   int n_points, n_queries, n_restarts, n_hits, n_settings;

   // ---------------------------------------------------------------------
   // Clock and reset
   // ---------------------------------------------------------------------
   initial clock = 1'b0;
   always #1 clock = ~clock;

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------
   task automatic clear_search();
      int k;
      for (k = 0; k < MAX_REFS; k++) begin
         closest_dist[k]  = '1;
         closest_point[k] = '0;
         has_pick[k]      = 1'b0;
      end
      point_seq  = '0;
      pick_total = '0;
   endtask

   task automatic predict_response(input request_type r);
      answer_type a;
      longint     dx, dy, d, limit;
      int         used, k;
      a.status       = STATUS_DONE;
      a.chosen_valid = 1'b0;
      a.chosen_index = '0;
      a.chosen_dist  = '0;
      a.selected     = 1'b0;
      case (r.cmd)
         CMD_LOAD: begin
            if (int'(r.slot) >= MAX_REFS) begin
               a.status = STATUS_SLOT_RANGE;
            end else begin
               anchor_x[r.slot] = r.pos_x;
               anchor_y[r.slot] = r.pos_y;
            end
         end
         CMD_POINT: begin
            n_points++;
            if (&point_seq) begin
               a.status = STATUS_SATURATED;
            end else begin
               // track counts beyond the table act as the full table
               used  = (int'(tracks_cfg) > MAX_REFS) ? MAX_REFS : int'(tracks_cfg);
               limit = longint'(sep_cfg) * longint'(sep_cfg);
               for (k = 0; k < used; k++) begin
                  dx = longint'(r.pos_x) - longint'(anchor_x[k]);
                  dy = longint'(r.pos_y) - longint'(anchor_y[k]);
                  d  = dx * dx + dy * dy;
                  // strictly closer than the best so far, and inside the radius
                  if (d < longint'(closest_dist[k]) && d <= limit) begin
                     if (!has_pick[k]) pick_total++;
                     has_pick[k]      = 1'b1;
                     closest_point[k] = point_seq;
                     closest_dist[k]  = DIST_BITS'(d);
                     a.selected       = 1'b1;
                  end
               end
               point_seq++;
            end
         end
         CMD_READ: begin
            if (int'(r.slot) >= MAX_REFS) begin
               a.status = STATUS_SLOT_RANGE;
            end else begin
               a.chosen_valid = has_pick[r.slot];
               a.chosen_index = closest_point[r.slot];
               a.chosen_dist  = closest_dist[r.slot];
            end
         end
         CMD_QUERY: begin
            n_queries++;
            for (k = 0; k < MAX_REFS; k++) begin
               if (has_pick[k] && closest_point[k] == r.query_index) a.selected = 1'b1;
            end
         end
         CMD_RESTART: begin
            n_restarts++;
            clear_search();
         end
         default: ;
      endcase
      a.count = pick_total;
      answers_due.push_back(a);
   endtask

   // ---------------------------------------------------------------------
   // Checking
   // ---------------------------------------------------------------------
   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
      n_errors++;
   endtask

   task automatic check_response();
      answer_type want;
      if (answers_due.size() == 0) begin
         report_mismatch("response with none outstanding", rsp_status, 0);
      end else begin
         want = answers_due.pop_front();
         n_answered++;
         if (rsp_point_selected) n_hits++;
         if (rsp_status !== want.status)
            report_mismatch("status", rsp_status, want.status);
         if (rsp_chosen_valid !== want.chosen_valid)
            report_mismatch("chosen_valid", rsp_chosen_valid, want.chosen_valid);
         if (rsp_chosen_index !== want.chosen_index)
            report_mismatch("chosen_index", rsp_chosen_index, want.chosen_index);
         if (rsp_chosen_dist_sq !== want.chosen_dist)
            report_mismatch("chosen_dist_sq", rsp_chosen_dist_sq, want.chosen_dist);
         if (rsp_point_selected !== want.selected)
            report_mismatch("point_selected", rsp_point_selected, want.selected);
         if (rsp_selected_count !== want.count)
            report_mismatch("selected_count", rsp_selected_count, want.count);
      end
   endtask

   // Rising edge: config writes and accepted requests go into the predictor,
   // accepted responses are checked against the oldest prediction.
   always @(posedge clock) begin : monitor
      request_type seen;
      if (reset) begin
         req_taken <= 1'b0;
         clear_search();
         sep_cfg    = '0;
         tracks_cfg = '0;
      end else begin
         req_taken <= req_valid && !req_stall;
         if (rsp_valid && !rsp_stall) check_response();
         if (csr_we) begin
            case (csr_index)
               CSR_MIN_SEP:     sep_cfg    = csr_wdata[SEP_W-1:0];
               CSR_TRACK_COUNT: tracks_cfg = csr_wdata[TRACK_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            seen.cmd         = req_cmd;
            seen.slot        = req_slot;
            seen.pos_x       = req_pos_x;
            seen.pos_y       = req_pos_y;
            seen.query_index = req_query_index;
            predict_response(seen);
         end
      end
   end

   // ---------------------------------------------------------------------
   // Driver: falling edge. A request stays put until taken; the next one
   // follows at once or, unless steady is set, after random idling.
   // ---------------------------------------------------------------------
   always @(negedge clock) begin : driver
      request_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (requests_pending.size() > 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
            nxt = requests_pending.pop_front();
            req_valid       <= 1'b1;
            req_cmd         <= nxt.cmd;
            req_slot        <= nxt.slot;
            req_pos_x       <= nxt.pos_x;
            req_pos_y       <= nxt.pos_y;
            req_query_index <= nxt.query_index;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response back-pressure
   always @(negedge clock) begin
      rsp_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   task automatic push_request(input logic [CMD_W-1:0] cmd, input int slot,
                               input logic signed [POS_W-1:0] x,
                               input logic signed [POS_W-1:0] y,
                               input logic [INDEX_W-1:0] q);
      request_type r;
      r.cmd         = cmd;
      r.slot        = SLOT_W'(slot);
      r.pos_x       = x;
      r.pos_y       = y;
      r.query_index = q;
      requests_pending.push_back(r);
      n_queued++;
      if (cmd == CMD_LOAD) begin
         plan_x[r.slot] = x;
         plan_y[r.slot] = y;
         loaded[r.slot] = 1'b1;
      end else if (cmd == CMD_POINT) begin
         plan_points++;
      end else if (cmd == CMD_RESTART) begin
         plan_points = 0;
      end
   endtask

   // full range, a small cluster around the origin, or an extreme
   function automatic logic signed [POS_W-1:0] any_coord();
      case ($urandom_range(3))
         1:       return POS_W'(longint'($urandom_range(8192)) - 64'sd4096);
         2:       return $urandom_range(1) ? POS_MAX : POS_MIN;
         default: return POS_W'($urandom);
      endcase
   endfunction

   // within +/- span of base; wraps at the coordinate width like the field
   function automatic logic signed [POS_W-1:0] near_coord(input logic signed [POS_W-1:0] base,
                                                          input int unsigned span);
      longint off;
      off = longint'($urandom_range(2 * span)) - longint'(span);
      return POS_W'(longint'(base) + off);
   endfunction

   task automatic random_request();
      int                      pick, k;
      logic signed [POS_W-1:0] x, y;
      logic [INDEX_W-1:0]      q;
      logic [CMD_W-1:0]        spare;
      pick = $urandom_range(99);
      if (pick < 50) begin
         // mostly points aimed at a slot in use, so choices really change
         if (plan_used > 0 && $urandom_range(9) < 7) begin
            k = $urandom_range(plan_used - 1);
            x = near_coord(plan_x[k], plan_span);
            y = near_coord(plan_y[k], plan_span);
         end else begin
            x = any_coord();
            y = any_coord();
         end
         push_request(CMD_POINT, $urandom_range(255), x, y, $urandom);
      end else if (pick < 60) begin
         k = (plan_used > 0 && $urandom_range(1)) ? $urandom_range(plan_used - 1)
                                                  : $urandom_range(MAX_REFS - 1);
         push_request(CMD_LOAD, k, any_coord(), any_coord(), $urandom);
      end else if (pick < 72) begin
         k = (plan_used > 0 && $urandom_range(1)) ? $urandom_range(plan_used - 1)
                                                  : $urandom_range(255);
         push_request(CMD_READ, k, any_coord(), any_coord(), $urandom);
      end else if (pick < 84) begin
         // recent point numbers hit, anything else mostly misses
         if (plan_points > 0 && $urandom_range(9) < 6)
            q = $urandom_range(plan_points - 1);
         else
            q = $urandom;
         push_request(CMD_QUERY, $urandom_range(255), any_coord(), any_coord(), q);
      end else if (pick < 88) begin
         push_request(CMD_RESTART, $urandom_range(255), any_coord(), any_coord(), $urandom);
      end else if (pick < 92) begin
         case ($urandom_range(2))
            0:       spare = CMD_SPARE_5;
            1:       spare = CMD_SPARE_6;
            default: spare = CMD_SPARE_7;
         endcase
         push_request(spare, $urandom_range(255), any_coord(), any_coord(), $urandom);
      end else begin
         push_request(CMD_POINT, $urandom_range(255), POS_W'($urandom), POS_W'($urandom),
                      $urandom);
      end
   endtask

   // every request gets exactly one response, so counts tell when all is back
   task automatic wait_drained();
      do @(negedge clock); while (n_answered != n_queued);
   endtask

   task automatic set_config(input logic [SEP_W-1:0] sep, input int tracks);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= CSR_MIN_SEP;
      csr_wdata <= CSR_DATA_W'(sep);
      @(negedge clock);
      csr_index <= CSR_TRACK_COUNT;
      csr_wdata <= CSR_DATA_W'(tracks);
      @(negedge clock);
      csr_we    <= 1'b0;
      n_settings++;
   endtask

   task automatic run_phase(input logic [SEP_W-1:0] sep, input int tracks, input int items,
                            input bit calm);
      int k;
      wait_drained();
      steady <= calm;
      set_config(sep, tracks);
      @(posedge clock);
      plan_span = sep;
      plan_used = (tracks > MAX_REFS) ? MAX_REFS : tracks;
      // every slot in use must hold a reference before a point walks it
      for (k = 0; k < plan_used; k++) begin
         if (!loaded[k]) push_request(CMD_LOAD, k, any_coord(), any_coord(), $urandom);
      end
      repeat (items) random_request();
   endtask

   // ---------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------
   initial begin
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_cmd         = '0;
      req_slot        = '0;
      req_pos_x       = '0;
      req_pos_y       = '0;
      req_query_index = '0;
      rsp_stall       = 1'b0;
      csr_we          = 1'b0;
      csr_index       = '0;
      csr_wdata       = '0;
      steady          = 1'b0;
      plan_used       = 0;
      plan_span       = 0;
      plan_points     = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings: no slots in use, zero radius. Empty table behavior,
      // ignored codes, and the reference loads used below.
      push_request(CMD_POINT, 0, '0, '0, '0);
      push_request(CMD_READ, 0, '0, '0, '0);
      push_request(CMD_QUERY, 0, '0, '0, '0);
      push_request(CMD_SPARE_5, 0, '0, '0, '0);
      push_request(CMD_SPARE_7, 255, POS_MAX, POS_MIN, '1);
      push_request(CMD_LOAD, 0, '0, '0, '0);
      push_request(CMD_LOAD, 1, POS_MAX, POS_MAX, '0);
      push_request(CMD_LOAD, 2, POS_MIN, POS_MIN, '0);
      push_request(CMD_LOAD, 3, POS_MAX, POS_MIN, '0);
      for (int k = 4; k < 8; k++) push_request(CMD_LOAD, k, any_coord(), any_coord(), '0);
      push_request(CMD_LOAD, 255, POS_MIN, POS_MAX, '1);

      // Widest radius, eight slots. Point number 0 becomes a first choice,
      // an equal distance does not replace a best, and the corner-to-corner
      // distance falls outside even the widest radius.
      wait_drained();
      set_config(SEP_MAX, 8);
      @(posedge clock);
      push_request(CMD_RESTART, 0, '0, '0, '0);
      push_request(CMD_POINT, 0, '0, '0, '0);
      push_request(CMD_POINT, 0, '0, '0, '0);
      push_request(CMD_POINT, 0, POS_MAX, POS_MAX, '0);
      push_request(CMD_POINT, 0, POS_MIN, POS_MIN, '0);
      push_request(CMD_READ, 0, '0, '0, '0);
      push_request(CMD_READ, 2, '0, '0, '0);
      push_request(CMD_QUERY, 0, '0, '0, '0);
      push_request(CMD_QUERY, 0, '0, '0, 1);
      push_request(CMD_QUERY, 0, '0, '0, '1);
      push_request(CMD_RESTART, 0, '0, '0, '0);
      push_request(CMD_READ, 0, '0, '0, '0);

      // Random phases: exact-hit radius, tiny and mid radii, the full table,
      // an oversized track count, no slots at all, and one calm stretch.
      run_phase('0, 16, 150, 1'b0);
      run_phase(SEP_W'(1), 3, 150, 1'b0);
      run_phase(SEP_W'(5000), 40, 150, 1'b1);
      run_phase(SEP_W'($urandom_range(200000)), 256, 100, 1'b0);
      run_phase(SEP_MAX, 511, 100, 1'b0);
      run_phase(SEP_W'(300), 1, 150, 1'b0);
      run_phase(SEP_W'(100000), 0, 100, 1'b0);
      run_phase(SEP_W'($urandom), 24, 100, 1'b0);

      wait_drained();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (answers_due.size() != 0)
         report_mismatch("responses never returned", answers_due.size(), 0);

      $display("ran %0d requests over %0d register settings: %0d points, %0d queries, %0d restarts",
               n_queued, n_settings, n_points, n_queries, n_restarts);
      $display("checked %0d responses, %0d reported a selected point, %0d mismatches",
               n_answered, n_hits, n_errors);
      if (n_errors == 0)
         $display("tb_closest_point_per_reference_select_top OK");
      else
         $display("tb_closest_point_per_reference_select_top NOT OK");
      $finish;
   end

   // watchdog
   initial begin
      #4000000;
      $display("timeout waiting for responses");
      $display("tb_closest_point_per_reference_select_top NOT OK");
      $finish;
   end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/cprs_pkg.sv
rtl/core/cprs_ctrl.sv
rtl/core/cprs_datapath.sv
rtl/core/closest_point_per_reference_select_top.sv
verif/tb_closest_point_per_reference_select_top.sv
